[design/camera_pose_gravity_convert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the camera pose gravity converter
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CAMERA_POSE_GRAVITY_CONVERT_MACROS_SVH
`define CAMERA_POSE_GRAVITY_CONVERT_MACROS_SVH

// condition implies a consequence in the same cycle
`define CPGC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies a consequence in the next cycle
`define CPGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cpgc_pkg.sv]
// ----------------------------------------------------------------------------
// cpgc_pkg
// Types, stage map and helpers shared by the pose converter and its
// normalization unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpgc_pkg;

    // lane geometry: four lanes, inputs carry a little headroom over 32 bits
    localparam int NL = 4;
    localparam int LW = 34;
    localparam int WW = 32;

    // normalization unit stage map
    localparam int NORM_STEPS = 5;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int U_SQ  = 0;
    localparam int U_SUM = 1;
    localparam int U_PRE = 2;
    localparam int U_NRM = 3;
    localparam int U_RT  = U_NRM + NORM_STEPS;
    localparam int U_NUM = U_RT + ROOT_STEPS;
    localparam int U_DV  = U_NUM + 1;
    localparam int U_FIN = U_DV + DIV_STEPS;
    localparam int U_LEN = U_FIN + 1;

    // gravity stages in the top level
    localparam int G_LEN = 3;

    localparam logic [WW-1:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [WW-1:0] MIN_S32 = 32'h8000_0000;
    localparam logic [WW-1:0] MAX_S32 = 32'h7FFF_FFFF;

    typedef logic [NL-1:0][LW-1:0] t_lanes;
    typedef logic [NL-1:0][WW-1:0] t_words;

    // sideband that rides along the whole pipe
    typedef struct packed {
        logic          degen;
        logic [WW-1:0] tx;
        logic [WW-1:0] ty;
        logic [WW-1:0] tz;
        t_words        nq;
    } t_side;

    // per-stage control and lane info inside the normalization unit
    typedef struct packed {
        t_side         side;
        logic [NL-1:0] sgn;
        t_words        mag;
        logic          flag;
        logic [5:0]    k;
    } t_carry;

    // saturating two's complement negation
    function automatic logic [WW-1:0] neg_sat(input logic [WW-1:0] v);
        logic [WW-1:0] r;
        r = (v == MIN_S32) ? MAX_S32 : (~v + 1'b1);
        return r;
    endfunction

endpackage

`default_nettype wire

[design/cpgc_unit.sv]
// ----------------------------------------------------------------------------
// cpgc_unit
// Pipelined unit-length scaler: sum of squares, even normalize shift,
// digit-by-digit square root, restoring division per lane, cap at 1.0 Q1.30.
// o_flag is set when the exact sum of squares is at or below i_limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cpgc_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_limit,
    input  logic             i_valid,
    input  cpgc_pkg::t_lanes i_lanes,
    input  cpgc_pkg::t_side  i_side,
    output logic             o_stall,
    input  logic             i_stall,
    output logic             o_valid,
    output cpgc_pkg::t_words o_words,
    output logic             o_flag,
    output cpgc_pkg::t_side  o_side
);
    import cpgc_pkg::*;

    logic [U_LEN-1:0] r_v;
    logic [U_LEN-1:0] n_v;
    logic [U_LEN-1:0] hold;
    t_carry           r_c [U_LEN];

    // a stage holds when it and everything after it is full and the sink stalls
    for (genvar j = 0; j < U_LEN; j++) begin : g_hold
        assign hold[j] = (&r_v[U_LEN-1:j]) & i_stall;
    end

    assign n_v = {r_v[U_LEN-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < U_LEN; j++) begin
                if (!hold[j]) begin
                    r_v[j] <= n_v[j];
                end
            end
        end
    end

    // magnitudes and squares
    logic [NL-1:0]          w_neg;
    logic [NL-1:0][LW-1:0]  w_abs;
    t_words                 w_mag;
    logic [NL-1:0][63:0]    r_sq;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_neg[i] = i_lanes[i][LW-1];
            w_abs[i] = w_neg[i] ? (~i_lanes[i] + 1'b1) : i_lanes[i];
            w_mag[i] = w_abs[i][WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold[U_SQ]) begin
            for (int i = 0; i < NL; i++) begin
                r_sq[i] <= 64'(w_mag[i]) * 64'(w_mag[i]);
            end
            r_c[U_SQ] <= '{side: i_side, sgn: w_neg, mag: w_mag, flag: 1'b0, k: 6'd0};
        end
    end

    // exact 65-bit sum
    logic [64:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!hold[U_SUM]) begin
            r_sum <= 65'(r_sq[0]) + 65'(r_sq[1]) + 65'(r_sq[2]) + 65'(r_sq[3]);
            r_c[U_SUM] <= r_c[U_SQ];
        end
    end

    // threshold compare and coarse scaling when the sum reaches 2^64
    logic [63:0] r_sp [NORM_STEPS+1];
    t_carry      n_cpre;

    always_comb begin
        n_cpre      = r_c[U_SUM];
        n_cpre.flag = (r_sum <= 65'(i_limit));
        n_cpre.k    = r_sum[64] ? 6'h3F : 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!hold[U_PRE]) begin
            r_sp[0]    <= r_sum[64] ? {1'b0, r_sum[64:2]} : r_sum[63:0];
            r_c[U_PRE] <= n_cpre;
        end
    end

    // even normalize shift, binary search 32/16/8/4/2 bits
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int         AMT = 32 >> j;
        localparam logic [5:0] INC = 6'(16 >> j);
        logic   w_zt;
        t_carry n_c;

        assign w_zt = (r_sp[j][63 -: AMT] == '0);

        always_comb begin
            n_c = r_c[U_NRM+j-1];
            if (w_zt) begin
                n_c.k = r_c[U_NRM+j-1].k + INC;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!hold[U_NRM+j]) begin
                r_sp[j+1]    <= w_zt ? (r_sp[j] << AMT) : r_sp[j];
                r_c[U_NRM+j] <= n_c;
            end
        end
    end

    // square root, one result bit per stage
    logic [33:0] r_rrem [ROOT_STEPS];
    logic [31:0] r_root [ROOT_STEPS];
    logic [63:0] r_spr  [ROOT_STEPS];

    for (genvar t = 0; t < ROOT_STEPS; t++) begin : g_root
        logic [33:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_spr;
        logic [35:0] w_rn;
        logic [35:0] w_tst;

        if (t == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_spr  = r_sp[NORM_STEPS];
        end else begin : g_next
            assign w_rem  = r_rrem[t-1];
            assign w_root = r_root[t-1];
            assign w_spr  = r_spr[t-1];
        end

        assign w_rn  = {w_rem, w_spr[63:62]};
        assign w_tst = {2'b00, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!hold[U_RT+t]) begin
                if (w_rn >= w_tst) begin
                    r_rrem[t] <= 34'(w_rn - w_tst);
                    r_root[t] <= {w_root[30:0], 1'b1};
                end else begin
                    r_rrem[t] <= w_rn[33:0];
                    r_root[t] <= {w_root[30:0], 1'b0};
                end
                r_spr[t]    <= w_spr << 2;
                r_c[U_RT+t] <= r_c[U_RT+t-1];
            end
        end
    end

    // dividends: |v| << (30 + k), plus half the root for rounding
    logic [NL-1:0][63:0] r_num;
    logic [31:0]         r_nroot;
    logic [5:0]          w_shamt;

    assign w_shamt = 6'd30 + r_c[U_NUM-1].k;

    always_ff @(posedge i_clk) begin
        if (!hold[U_NUM]) begin
            for (int i = 0; i < NL; i++) begin
                r_num[i] <= (64'(r_c[U_NUM-1].mag[i]) << w_shamt)
                          + 64'(r_root[ROOT_STEPS-1] >> 1);
            end
            r_nroot    <= r_root[ROOT_STEPS-1];
            r_c[U_NUM] <= r_c[U_NUM-1];
        end
    end

    // restoring division, one quotient bit per stage on every lane
    t_words      r_drem [DIV_STEPS];
    t_words      r_dq   [DIV_STEPS];
    logic [31:0] r_dr   [DIV_STEPS];

    for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
        t_words               w_rem;
        t_words               w_dq;
        logic [31:0]          w_r;
        logic [NL-1:0][32:0]  w_t;
        logic [NL-1:0]        w_ge;

        if (t == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < NL; i++) begin
                    w_rem[i] = r_num[i][63:32];
                    w_dq[i]  = r_num[i][31:0];
                end
            end
            assign w_r = r_nroot;
        end else begin : g_next
            assign w_rem = r_drem[t-1];
            assign w_dq  = r_dq[t-1];
            assign w_r   = r_dr[t-1];
        end

        always_comb begin
            for (int i = 0; i < NL; i++) begin
                w_t[i]  = {w_rem[i], w_dq[i][31]};
                w_ge[i] = (w_t[i] >= {1'b0, w_r});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!hold[U_DV+t]) begin
                for (int i = 0; i < NL; i++) begin
                    r_drem[t][i] <= w_ge[i] ? 32'(w_t[i] - {1'b0, w_r}) : w_t[i][31:0];
                    r_dq[t][i]   <= {w_dq[i][30:0], w_ge[i]};
                end
                r_dr[t]     <= w_r;
                r_c[U_DV+t] <= r_c[U_DV+t-1];
            end
        end
    end

    // cap at 1.0 and restore sign
    t_words r_out;
    t_words w_cap;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_cap[i] = (r_dq[DIV_STEPS-1][i] > ONE_Q30) ? ONE_Q30 : r_dq[DIV_STEPS-1][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold[U_FIN]) begin
            for (int i = 0; i < NL; i++) begin
                r_out[i] <= r_c[U_FIN-1].sgn[i] ? (~w_cap[i] + 1'b1) : w_cap[i];
            end
            r_c[U_FIN] <= r_c[U_FIN-1];
        end
    end

    assign o_stall = hold[0];
    assign o_valid = r_v[U_LEN-1];
    assign o_words = r_out;
    assign o_flag  = r_c[U_FIN].flag;
    assign o_side  = r_c[U_FIN].side;

endmodule

`default_nettype wire

[design/camera_pose_gravity_convert.sv]
// ----------------------------------------------------------------------------
// camera_pose_gravity_convert
// Normalizes a world-to-camera quaternion, flips the pose about camera +X,
// negates translation y/z with saturation and derives the unit gravity
// direction in the camera frame.
// ----------------------------------------------------------------------------
//  Channel   Dir  Width          Beat contents
//  s_axis    in   224            quat_w/x/y/z (Q3.28), trans_x/y/z (Q16.16)
//  m_axis    out  320 + user 1   quaternion, translation, gravity; user=status
//  cfg       in   32             degenerate_norm_sq_limit
//
//  One beat per cycle in and out unless m_axis stalls; the pipe is two
//  normalization units of 74 stages each (mostly 32 square-root and 32
//  division stages), three gravity stages and the output register.
//  Reset (synchronous, active low) clears all valid bits and the limit.
//  A stall on m_axis freezes only the stages that are full; bubbles keep
//  filling, so s_axis stays ready until every stage holds a beat.
//  cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_pose_gravity_convert (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_quat_w/x/y/z, out_trans_x/y/z, grav_x/y/z
    output logic [319:0] m_axis_tdata,
    // status
    output logic [0:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);
    import cpgc_pkg::*;

`include "camera_pose_gravity_convert_macros.svh"

    // limit register
    logic [31:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // input unpack
    t_lanes w_qlanes;
    t_side  w_iside;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_qlanes[i] = LW'($signed(s_axis_tdata[i*WW +: WW]));
        end
        w_iside.degen = 1'b0;
        w_iside.tx    = s_axis_tdata[4*WW +: WW];
        w_iside.ty    = neg_sat(s_axis_tdata[5*WW +: WW]);
        w_iside.tz    = neg_sat(s_axis_tdata[6*WW +: WW]);
        w_iside.nq    = '0;
    end

    // quaternion normalization
    logic   u1_stall;
    logic   u1_valid;
    t_words u1_words;
    logic   u1_flag;
    t_side  u1_side;
    logic [G_LEN-1:0] hold_g;

    cpgc_unit u_qnorm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_limit),
        .i_valid (s_axis_tvalid),
        .i_lanes (w_qlanes),
        .i_side  (w_iside),
        .o_stall (u1_stall),
        .i_stall (hold_g[0]),
        .o_valid (u1_valid),
        .o_words (u1_words),
        .o_flag  (u1_flag),
        .o_side  (u1_side)
    );

    assign s_axis_tready = !u1_stall;

    // gravity stages: products, combine, round to Q.29
    logic [G_LEN-1:0] r_gv;
    logic [G_LEN-1:0] n_gv;
    logic             u2_stall;
    t_side            r_gside [G_LEN];
    t_side            w_gside;
    logic signed [63:0] r_p [6];
    logic signed [63:0] r_g [3];
    t_lanes           r_glanes;
    t_lanes           w_glanes;

    for (genvar j = 0; j < G_LEN; j++) begin : g_ghold
        assign hold_g[j] = (&r_gv[G_LEN-1:j]) & u2_stall;
    end

    assign n_gv = {r_gv[G_LEN-2:0], u1_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= '0;
        end else begin
            for (int j = 0; j < G_LEN; j++) begin
                if (!hold_g[j]) begin
                    r_gv[j] <= n_gv[j];
                end
            end
        end
    end

    always_comb begin
        w_gside       = u1_side;
        w_gside.degen = u1_flag;
        w_gside.nq    = u1_words;
    end

    // lanes: 0 w, 1 x, 2 y, 3 z
    always_ff @(posedge i_clk) begin
        if (!hold_g[0]) begin
            r_p[0]     <= $signed(u1_words[0]) * $signed(u1_words[3]);
            r_p[1]     <= $signed(u1_words[1]) * $signed(u1_words[2]);
            r_p[2]     <= $signed(u1_words[1]) * $signed(u1_words[1]);
            r_p[3]     <= $signed(u1_words[3]) * $signed(u1_words[3]);
            r_p[4]     <= $signed(u1_words[0]) * $signed(u1_words[1]);
            r_p[5]     <= $signed(u1_words[2]) * $signed(u1_words[3]);
            r_gside[0] <= w_gside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_g[1]) begin
            r_g[0]     <= (r_p[0] - r_p[1]) <<< 1;
            r_g[1]     <= 64'sh1000_0000_0000_0000 - ((r_p[2] + r_p[3]) <<< 1);
            r_g[2]     <= (r_p[4] + r_p[5]) <<< 1;
            r_gside[1] <= r_gside[0];
        end
    end

    // Q.60 to Q.29, half away from zero
    logic [2:0]        w_gneg;
    logic [2:0][63:0]  w_gmag;
    logic [2:0][32:0]  w_grnd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_gneg[i]   = r_g[i][63];
            w_gmag[i]   = w_gneg[i] ? (~r_g[i] + 1'b1) : r_g[i];
            w_grnd[i]   = 33'((w_gmag[i] + 64'h4000_0000) >> 31);
            w_glanes[i] = w_gneg[i] ? (~{1'b0, w_grnd[i]} + 1'b1) : {1'b0, w_grnd[i]};
        end
        w_glanes[3] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!hold_g[2]) begin
            r_glanes   <= w_glanes;
            r_gside[2] <= r_gside[1];
        end
    end

    // gravity normalization
    logic   u2_valid;
    t_words u2_words;
    logic   u2_flag;
    t_side  u2_side;
    logic   hold_o;

    cpgc_unit u_gnorm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (32'd0),
        .i_valid (r_gv[G_LEN-1]),
        .i_lanes (r_glanes),
        .i_side  (r_gside[G_LEN-1]),
        .o_stall (u2_stall),
        .i_stall (hold_o),
        .o_valid (u2_valid),
        .o_words (u2_words),
        .o_flag  (u2_flag),
        .o_side  (u2_side)
    );

    // output register
    logic         r_ov;
    logic         r_ostat;
    logic [319:0] r_odata;
    logic         w_stat;
    logic [319:0] w_odata;

    assign hold_o = r_ov & !m_axis_tready;

    always_comb begin
        w_stat  = u2_side.degen | u2_flag;
        w_odata = {u2_words[2], u2_words[1], u2_words[0],
                   u2_side.tz, u2_side.ty, u2_side.tx,
                   u2_side.nq[2], ~u2_side.nq[3] + 1'b1,
                   u2_side.nq[0], ~u2_side.nq[1] + 1'b1};
        if (w_stat) begin
            w_odata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!hold_o) begin
            r_ov <= u2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_o) begin
            r_ostat <= w_stat;
            r_odata <= w_odata;
        end
    end

    assign m_axis_tvalid   = r_ov;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tuser[0] = r_ostat;

    // checks
    `CPGC_ASSERT_SAME(a_degen_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "degenerate beat carries nonzero data")
    `CPGC_ASSERT_SAME(a_quat_range, m_axis_tvalid && !m_axis_tuser[0], ($signed(m_axis_tdata[31:0]) <= 32'sd1073741824) && ($signed(m_axis_tdata[31:0]) >= -32'sd1073741824), "quaternion out of Q1.30 unit range")
    `CPGC_ASSERT_SAME(a_stall_full, !s_axis_tready, (&r_gv) && r_ov, "input stalled while pipeline has a bubble")
    `CPGC_ASSERT_NEXT(a_grav_load, u1_valid && !hold_g[0], r_gv[0], "gravity stage dropped a beat")

endmodule

`default_nettype wire

[tb/tb_camera_pose_gravity_convert.sv]
// ----------------------------------------------------------------------------
// Testbench for camera_pose_gravity_convert
// Drives poses on the input stream with random gaps, predicts the normalized
// quaternion, flipped translation and gravity direction per pose, and checks
// each output beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_camera_pose_gravity_convert;

    localparam int PIPE_LAT = 152;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_DEGEN = 1'b1;

    typedef struct packed {
        logic [31:0] tz;
        logic [31:0] ty;
        logic [31:0] tx;
        logic [31:0] qz;
        logic [31:0] qy;
        logic [31:0] qx;
        logic [31:0] qw;
    } t_pose;

    typedef struct {
        logic        status;
        logic [31:0] f [10];
    } t_pose_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [319:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;

    camera_pose_gravity_convert dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    logic [31:0]  norm_limit;
    t_pose_result pending_poses[$];
    int           n_fail;
    int           n_sent;
    int           n_recv;
    int           n_degen;
    bit           sink_stall_en;
    int           sink_wait;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale n lanes to unit length in Q1.30; returns 0 on a zero vector
    function automatic bit unit_scale(input logic signed [63:0] v [4], input int n,
                                      output logic signed [63:0] u [4]);
        logic [64:0] s;
        logic [63:0] sp, r, m, num, q;
        int          k;
        s = 0;
        for (int i = 0; i < 4; i++) u[i] = 0;
        for (int i = 0; i < n; i++) s = s + 65'(mag_of(v[i]) * mag_of(v[i]));
        if (s[64]) begin
            sp = (64'd1 << 62) | (s[63:0] >> 2);
            k = -1;
        end else begin
            sp = s[63:0];
            k = 0;
        end
        if (sp == 0) return 0;
        while (sp < (64'd1 << 62)) begin
            sp = sp << 2;
            k++;
        end
        r = int_sqrt(sp);
        for (int i = 0; i < n; i++) begin
            m = mag_of(v[i]);
            num = (k < 0) ? (m << 29) : (m << (30 + k));
            q = (num + (r >> 1)) / r;
            if (q > 64'd1 << 30) q = 64'd1 << 30;
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    function automatic logic signed [63:0] q60_to_q29(input logic signed [63:0] v);
        logic [63:0] m;
        m = (mag_of(v) + (64'd1 << 30)) >> 31;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] negate_sat(input logic [31:0] v);
        return v == 32'h8000_0000 ? 32'h7FFF_FFFF : -v;
    endfunction

    function automatic t_pose_result predict_pose(input t_pose p);
        t_pose_result         res;
        logic signed [63:0]   q [4], nq [4], g [4], gu [4];
        logic [64:0]          s;
        res.status = STAT_DEGEN;
        for (int i = 0; i < 10; i++) res.f[i] = 0;
        q[0] = $signed(p.qw);
        q[1] = $signed(p.qx);
        q[2] = $signed(p.qy);
        q[3] = $signed(p.qz);
        s = 0;
        for (int i = 0; i < 4; i++) s = s + 65'(mag_of(q[i]) * mag_of(q[i]));
        if (s <= 65'(norm_limit)) return res;
        void'(unit_scale(q, 4, nq));
        g[0] = q60_to_q29(2 * (nq[0] * nq[3] - nq[1] * nq[2]));
        g[1] = q60_to_q29((64'sd1 <<< 60) - 2 * (nq[1] * nq[1] + nq[3] * nq[3]));
        g[2] = q60_to_q29(2 * (nq[0] * nq[1] + nq[2] * nq[3]));
        g[3] = 0;
        if (!unit_scale(g, 3, gu)) return res;
        res.status = STAT_OK;
        res.f[0] = 32'(-nq[1]);
        res.f[1] = 32'(nq[0]);
        res.f[2] = 32'(-nq[3]);
        res.f[3] = 32'(nq[2]);
        res.f[4] = p.tx;
        res.f[5] = negate_sat(p.ty);
        res.f[6] = negate_sat(p.tz);
        res.f[7] = 32'(gu[0]);
        res.f[8] = 32'(gu[1]);
        res.f[9] = 32'(gu[2]);
        return res;
    endfunction

    // ---------------- output checker ----------------
    always @(posedge i_clk) begin
        t_pose_result exp_r;
        string        names [10];
        names = '{"out_quat_w", "out_quat_x", "out_quat_y", "out_quat_z", "out_trans_x",
                  "out_trans_y", "out_trans_z", "grav_x", "grav_y", "grav_z"};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_recv++;
            if (pending_poses.size() == 0) begin
                $error("output beat with no pose pending");
                n_fail++;
            end else begin
                exp_r = pending_poses.pop_front();
                if (exp_r.status == STAT_DEGEN) n_degen++;
                if (m_axis_tuser[0] !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_axis_tuser[0]);
                    n_fail++;
                end
                for (int i = 0; i < 10; i++)
                    if (m_axis_tdata[32*i +: 32] !== exp_r.f[i]) begin
                        $error("%s exp %0d got %0d", names[i], $signed(exp_r.f[i]),
                               $signed(m_axis_tdata[32*i +: 32]));
                        n_fail++;
                    end
            end
        end
    end

    // back-pressure on the output: after each beat the sink draws a random wait before it is ready again
    always @(posedge i_clk) begin
        if (!sink_stall_en) begin
            m_axis_tready <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            sink_wait = $urandom_range(0, 9);
            m_axis_tready <= (sink_wait == 0);
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= (sink_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_pose(input t_pose p, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_poses.push_back(predict_pose(p));
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        norm_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 65535)) - 32768);
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        endcase
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        p.qw = rand_q();
        p.qx = rand_q();
        p.qy = rand_q();
        p.qz = rand_q();
        p.tx = $urandom();
        p.ty = ($urandom_range(0, 15) == 0) ? 32'h8000_0000 : $urandom();
        p.tz = ($urandom_range(0, 15) == 0) ? 32'h8000_0000 : $urandom();
        return p;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        t_pose p;
        logic [31:0] ext [6];
        ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1000_0000};
        // zero quaternion is degenerate at limit 0
        p = '0;
        send_pose(p, 0);
        // all extremes on each lane
        for (int i = 0; i < 6; i++) begin
            p = '{tz: ext[(i + 3) % 6], ty: ext[(i + 1) % 6], tx: ext[i],
                  qz: ext[(i + 4) % 6], qy: ext[(i + 2) % 6], qx: ext[(i + 5) % 6],
                  qw: ext[i]};
            send_pose(p, 0);
        end
        // all four lanes at the most negative value: sum of squares overflows 64 bits
        p = '{default: 32'h8000_0000};
        send_pose(p, 0);
        p = '{default: 32'h7FFF_FFFF};
        send_pose(p, 0);
        // single-lane unit quaternions
        for (int i = 0; i < 4; i++) begin
            p = '0;
            p[32*i +: 32] = 32'h1000_0000;
            send_pose(p, 0);
            p[32*i +: 32] = 32'hF000_0000;
            send_pose(p, 0);
        end
    endtask

    task automatic test_limit_edges();
        t_pose p;
        // squared norm of 1 LSB sits right on the limit and just above it
        wait_drained();
        write_limit(32'd1);
        p = '0;
        p.qx = 32'd1;
        send_pose(p, 0);
        p.qy = 32'hFFFF_FFFF;
        send_pose(p, 0);
        wait_drained();
        write_limit(32'hFFFF_FFFF);
        p = '0;
        p.qw = 32'd65535;
        send_pose(p, 0);
        p.qw = 32'd65536;
        send_pose(p, 0);
        p.qw = 32'hFFFF_0001;
        send_pose(p, 0);
    endtask

    task automatic test_random(input int n, input bit gaps);
        for (int i = 0; i < n; i++) send_pose(rand_pose(), gaps);
    endtask

    task automatic test_limit_sweep();
        logic [31:0] lims [3];
        lims = '{32'h0000_0000, $urandom(), 32'hFFFF_FFFF};
        foreach (lims[i]) begin
            wait_drained();
            write_limit(lims[i]);
            test_random(60, 1);
        end
    endtask

    initial begin
        n_fail = 0;
        n_sent = 0;
        n_recv = 0;
        n_degen = 0;
        norm_limit = 0;
        sink_stall_en = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limit_edges();
        wait_drained();
        write_limit(32'd0);
        // back-to-back with no stalls, then random gaps and back-pressure
        test_random(150, 0);
        sink_stall_en = 1'b1;
        test_random(250, 1);
        // hold off until the pipe has emptied, then continue
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        test_random(100, 1);
        test_limit_sweep();

        wait_drained();
        $display("sent %0d poses, checked %0d beats (%0d degenerate), limits 0..max",
                 n_sent, n_recv, n_degen);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
